/* hdl/bdq_pkg.sv */
`default_nettype none

package bdq_pkg;

  // Fixed field widths
  localparam int KIND_W  = 3;
  localparam int POS_W   = 8;
  localparam int DATA_W  = 8;
  localparam int STAT_W  = 2;

  // Default number of ring slots
  localparam int BDQ_DEPTH = 256;

  // Request kinds; the unused code is caught by a default arm
  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_ADD        = 3'd6
  } kind_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Slot action carried to the write-back stage
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_ADD   = 2'd3
  } act_t;

endpackage

`default_nettype wire

/* hdl/bdq_ram.sv */
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/byte_deque_indexed_top.sv */
`default_nettype none
// Bounded byte deque with indexed access, held in a ring of DEPTH slots.
// Input channel (in_valid/in_ready): one request with in_kind, in_position,
// in_value. Kinds: push front, pop front, push back, pop back, and read,
// write or add (mod 256) at an index counted from the front.
// Result channel (out_valid/out_ready): one result per request with the byte
// popped or read (zero otherwise), a status (ok, empty/out of range, full)
// and the entry count after the request.
// A request goes from the issue stage to the output register (out_valid) when
// that register is free. Throughput: one request per cycle while the output
// is not stalled. A request reads the slot RAM in the cycle it is taken and
// writes back as it leaves the issue stage; a forwarding register covers a
// request that reads the slot its predecessor writes.
// Stall: an issue stage and an output register sit between the channels, so
// one request is still taken while a finished result waits; after that
// in_ready drops until out_ready frees the output register.
// Reset (rst_n low, synchronous): front pointer and count go to zero and the
// pipeline empties. Slot contents are not cleared and need no clearing pass;
// only slots written by a push are ever read.
module byte_deque_indexed_top #(
  parameter int DEPTH = bdq_pkg::BDQ_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bdq_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [bdq_pkg::POS_W-1:0]        in_position,
  input  wire logic [bdq_pkg::DATA_W-1:0]       in_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [bdq_pkg::DATA_W-1:0]       out_value,
  output logic      [bdq_pkg::STAT_W-1:0]       out_status,
  output logic      [$clog2(DEPTH+1)-1:0]       out_entries
);

  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Ring state
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;

  // Issue stage (request waiting on its slot read)
  logic              s1_valid_r;
  act_t              s1_act_r, act_nxt;
  logic [AW-1:0]     s1_addr_r;
  logic [DATA_W-1:0] s1_value_r;
  status_t           s1_status_r, status_nxt;
  logic [CW-1:0]     s1_entries_r;

  // Forwarding of a write that collides with the next read
  logic              fwd_hit_r;
  logic [DATA_W-1:0] fwd_data_r;

  // Output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  status_t           out_status_r;
  logic [CW-1:0]     out_entries_r;

  logic              accept, s1_adv;
  logic [XW-1:0]     offset, sum_raw, sum_wrap, inc_raw, inc_wrap;
  logic [AW-1:0]     ring_addr;
  logic              full, empty, pos_bad;
  logic [DATA_W-1:0] ram_rdata, slot_data, wr_data;
  logic              wr_en;

  // Handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign full    = (fill_r == CW'(DEPTH));
  assign empty   = (fill_r == '0);
  assign pos_bad = (XW'(in_position) >= XW'(fill_r));

  // Ring address: front plus offset, wrapped once
  assign sum_raw   = XW'(front_r) + offset;
  assign sum_wrap  = (sum_raw >= XW'(DEPTH)) ? (sum_raw - XW'(DEPTH)) : sum_raw;
  assign ring_addr = sum_wrap[AW-1:0];

  // Front after a pop front
  assign inc_raw  = XW'(front_r) + XW'(1);
  assign inc_wrap = (inc_raw >= XW'(DEPTH)) ? '0 : inc_raw;

  // Request decode, status and pointer update
  always_comb begin
    offset     = '0;
    act_nxt    = ACT_NONE;
    status_nxt = STAT_OK;
    front_nxt  = front_r;
    fill_nxt   = fill_r;
    unique case (in_kind)
      OP_PUSH_FRONT: begin
        offset = XW'(DEPTH - 1);
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          act_nxt   = ACT_WRITE;
          front_nxt = ring_addr;
          fill_nxt  = fill_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = STAT_RANGE;
        end else begin
          act_nxt   = ACT_READ;
          front_nxt = inc_wrap[AW-1:0];
          fill_nxt  = fill_r - CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        offset = XW'(fill_r);
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          act_nxt  = ACT_WRITE;
          fill_nxt = fill_r + CW'(1);
        end
      end
      OP_POP_BACK: begin
        offset = XW'(fill_r - CW'(1));
        if (empty) begin
          status_nxt = STAT_RANGE;
        end else begin
          act_nxt  = ACT_READ;
          fill_nxt = fill_r - CW'(1);
        end
      end
      OP_READ, OP_WRITE, OP_ADD: begin
        offset = XW'(in_position);
        if (pos_bad) begin
          status_nxt = STAT_RANGE;
        end else if (in_kind == OP_READ) begin
          act_nxt = ACT_READ;
        end else if (in_kind == OP_WRITE) begin
          act_nxt = ACT_WRITE;
        end else begin
          act_nxt = ACT_ADD;
        end
      end
      default: begin
        status_nxt = STAT_RANGE;
      end
    endcase
  end

  // Slot data seen by the issue stage
  assign slot_data = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign wr_en     = s1_adv && ((s1_act_r == ACT_WRITE) || (s1_act_r == ACT_ADD));
  assign wr_data   = (s1_act_r == ACT_ADD) ? (slot_data + s1_value_r) : s1_value_r;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (ring_addr),
    .rd_data (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        front_r <= front_nxt;
        fill_r  <= fill_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= accept;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Issue stage payload and forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r     <= act_nxt;
      s1_addr_r    <= ring_addr;
      s1_value_r   <= in_value;
      s1_status_r  <= status_nxt;
      s1_entries_r <= fill_nxt;
      fwd_hit_r    <= wr_en && (s1_addr_r == ring_addr);
      fwd_data_r   <= wr_data;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r   <= (s1_act_r == ACT_READ) ? slot_data : '0;
      out_status_r  <= s1_status_r;
      out_entries_r <= s1_entries_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_status  = out_status_r;
  assign out_entries = out_entries_r;

`ifndef SYNTHESIS
  // Count never passes the ring size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  // A failed request never touches a slot
  a_fail_no_act: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_status_r != STAT_OK) |-> (s1_act_r == ACT_NONE))
    else $error("failed request carries a slot action");

  // Reported count matches the ring state right after the request
  a_entries_sync: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (s1_entries_r == fill_r))
    else $error("issued count differs from fill");

  // A taken request always reaches the issue stage
  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted request lost");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH       = bdq_pkg::BDQ_DEPTH;
  localparam int ENT_W       = $clog2(DEPTH + 1);
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;

  // Kind code 7 is not a member of kind_t; the block must reject it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic [ENT_W-1:0]  entries;
  } deque_result_t;

  // Scoreboard: tracks the deque contents and holds the pending results
  class deque_scoreboard;
    bit [DATA_W-1:0] slot_mem [DEPTH];
    int              head;
    int              count;
    int              errors;
    deque_result_t   expected_q [$];

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int fill_level();
      return count;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request and queue the result it should give
    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
      deque_result_t res;
      int            at;
      res.value  = '0;
      res.status = STAT_OK;
      at = (head + int'(pos)) % DEPTH;
      case (kind)
        OP_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            res.status = STAT_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slot_mem[head] = val;
            count++;
          end
        end
        OP_POP_FRONT: begin
          if (count == 0) begin
            res.status = STAT_RANGE;
          end else begin
            res.value = slot_mem[head];
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        OP_PUSH_BACK: begin
          if (count >= DEPTH) begin
            res.status = STAT_FULL;
          end else begin
            slot_mem[(head + count) % DEPTH] = val;
            count++;
          end
        end
        OP_POP_BACK: begin
          if (count == 0) begin
            res.status = STAT_RANGE;
          end else begin
            res.value = slot_mem[(head + count - 1) % DEPTH];
            count--;
          end
        end
        OP_READ, OP_WRITE, OP_ADD: begin
          if (int'(pos) >= count) begin
            res.status = STAT_RANGE;
          end else if (kind == OP_READ) begin
            res.value = slot_mem[at];
          end else if (kind == OP_WRITE) begin
            slot_mem[at] = val;
          end else begin
            // sum wraps at 8 bits
            slot_mem[at] = slot_mem[at] + val;
          end
        end
        default: begin
          res.status = STAT_RANGE;
        end
      endcase
      res.entries = count[ENT_W-1:0];
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result with the oldest pending one
    function void check_result(logic [DATA_W-1:0] value, logic [STAT_W-1:0] status,
                               logic [ENT_W-1:0] entries);
      deque_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: value %0d status %0d entries %0d",
               value, status, entries);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value) begin
        $error("out_value: expected %0d, got %0d", exp_res.value, value);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("out_status: expected %0d, got %0d", exp_res.status, status);
        errors++;
      end
      if (entries !== exp_res.entries) begin
        $error("out_entries: expected %0d, got %0d", exp_res.entries, entries);
        errors++;
      end
    endfunction
  endclass

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind     = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [DATA_W-1:0] in_value    = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [DATA_W-1:0] out_value;
  logic [STAT_W-1:0] out_status;
  logic [ENT_W-1:0]  out_entries;

  bit ready_hold = 1'b0;
  bit calm_tail  = 1'b0;
  int stall_cycles = 0;

  deque_scoreboard book = new();

  byte_deque_indexed_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_position(in_position),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status),
    .out_entries(out_entries)
  );

  always #4 clk = ~clk;

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_request(kind, pos, val);
  endtask

  // Random idle burst on the request side, skipped in the tail and during a hold
  task automatic maybe_idle();
    int n;
    if (!calm_tail && !ready_hold && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_paced(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
    maybe_idle();
    send_request(kind, pos, val);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(int push_w, int pop_w, int idx_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_w) begin
      return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else if (r < push_w + pop_w) begin
      return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
    end else if (r < push_w + pop_w + idx_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_READ;
        1:       return OP_WRITE;
        default: return OP_ADD;
      endcase
    end
    return KIND_UNUSED;
  endfunction

  // One stretch of random requests with a given mix; hold_at >= 0 stalls the receiver
  task automatic run_phase(int items, int push_w, int pop_w, int idx_w, int hold_at);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int                n;
    int                r;
    for (int i = 0; i < items; i++) begin
      if (i == hold_at) ready_hold = 1'b1;
      kind = pick_kind(push_w, pop_w, idx_w);
      n = book.fill_level();
      if (n > 0 && $urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, n - 1));
      else pos = POS_W'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      if (r == 0) val = 8'h00;
      else if (r == 1) val = 8'hFF;
      else val = DATA_W'($urandom_range(0, 255));
      send_paced(kind, pos, val);
    end
  endtask

  // Result side: random stall bursts, a long hold on request, always ready in the tail
  initial begin : receiver
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (ready_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        ready_hold = 1'b0;
      end else if (calm_tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Result check and watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        book.check_result(out_value, out_status, out_entries);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-deque errors, unused kind, pointer wrap, add wrap
    send_paced(OP_POP_FRONT,  8'd0,   8'd0);
    send_paced(OP_POP_BACK,   8'd0,   8'd0);
    send_paced(OP_READ,       8'd0,   8'd0);
    send_paced(OP_WRITE,      8'd0,   8'hFF);
    send_paced(OP_ADD,        8'd255, 8'hFF);
    send_paced(KIND_UNUSED,   8'd0,   8'd0);
    send_paced(OP_PUSH_BACK,  8'd0,   8'hFF);
    send_paced(OP_POP_BACK,   8'd0,   8'd0);
    send_paced(OP_PUSH_FRONT, 8'd0,   8'h00);
    send_paced(OP_PUSH_FRONT, 8'd0,   8'hFF);
    send_paced(OP_PUSH_BACK,  8'd0,   8'h80);
    send_paced(OP_READ,       8'd0,   8'd0);
    send_paced(OP_READ,       8'd2,   8'd0);
    send_paced(OP_READ,       8'd3,   8'd0);
    send_paced(OP_WRITE,      8'd1,   8'h7F);
    send_paced(OP_ADD,        8'd0,   8'h01);
    send_paced(OP_ADD,        8'd2,   8'hFF);
    send_paced(OP_READ,       8'd0,   8'd0);
    send_paced(OP_READ,       8'd1,   8'd0);
    send_paced(KIND_UNUSED,   8'd255, 8'hFF);
    send_paced(OP_POP_FRONT,  8'd0,   8'd0);
    send_paced(OP_POP_BACK,   8'd0,   8'd0);
    send_paced(OP_POP_FRONT,  8'd0,   8'd0);
    send_paced(OP_POP_FRONT,  8'd0,   8'd0);

    // Random: mixed, fill to full, indexed at full, drain, calm tail
    run_phase(150, 40, 25, 33, -1);
    run_phase(350, 75, 10, 14, 20);
    run_phase(200, 20, 10, 69, 50);
    run_phase(350, 15, 60, 24, -1);
    calm_tail = 1'b1;
    run_phase(200, 40, 30, 29, -1);
    in_valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (book.pending() != 0) begin
      $error("%0d results never arrived", book.pending());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
